@@ rtl/swte_pkg.sv @@
// shared types, codes and prescaler lookups for the square wave timer
package swte_pkg;

  localparam int HZ_W    = 16;
  localparam int CMP_W   = 16;
  localparam int SEL_W   = 3;
  localparam int PSC_W   = 10;
  localparam int DBL_W   = 17;
  localparam int SHIFT_W = 4;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [SEL_W-1:0] SEL_STOP = 3'd0;

  typedef struct packed {
    logic            kind;
    logic [HZ_W-1:0] hz;
  } swte_in_t;

  typedef struct packed {
    logic             wave_level;
    logic             running;
    logic [SEL_W-1:0] prescale_code;
    logic [CMP_W-1:0] compare_value;
  } swte_out_t;

  // prescaler period for a select code (1..7)
  function automatic logic [PSC_W:0] presc_div(input logic [SEL_W-1:0] code);
    logic [PSC_W:0] d;
    case (code)
      3'd1:    d = 11'd1;
      3'd2:    d = 11'd8;
      3'd3:    d = 11'd32;
      3'd4:    d = 11'd64;
      3'd5:    d = 11'd128;
      3'd6:    d = 11'd256;
      3'd7:    d = 11'd1024;
      default: d = 11'd1;
    endcase
    return d;
  endfunction

  // log2 of the prescaler at search index 0..6
  function automatic logic [SHIFT_W-1:0] presc_shift(input logic [SEL_W-1:0] idx);
    logic [SHIFT_W-1:0] s;
    case (idx)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      3'd6:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/swte_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module swte_div
  import swte_pkg::*;
#(
  parameter int NW  = 24,
  parameter int DSW = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DSW-1:0]   rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DSW-1:0]   dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DSW:0]     shifted;
  logic [DSW:0]     diff;

  always_comb begin
    shifted  = {rem_r, quo_r[NW-1]};
    diff     = shifted - {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits hold it
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DSW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DSW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/square_wave_timer_extended.sv @@
// tick beat: result registered the cycle after accept; one per cycle unless output stalls
// set beat: restoring divider (as wide as CLOCK_HZ) forms CLOCK_HZ / (2 * hz), then
//   1..NUM_PRESCALERS prescaler trials through one shift-and-compare unit, then result is
//   registered and the next beat is taken back in idle; zero hz skips divider and search
// no new beat is taken while a set beat is being worked on
// synchronous active-low reset clears all timer state, output level and output valid
module square_wave_timer_extended
  import swte_pkg::*;
#(
  parameter int CLOCK_HZ       = 16000000,
  parameter int NUM_PRESCALERS = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  swte_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output swte_out_t out_data
);

  localparam int DIV_W = $clog2(CLOCK_HZ + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [SEL_W-1:0] idx_r, idx_nxt;
  logic             run_r, run_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic [CMP_W-1:0] cmp_r, cmp_nxt;
  logic [PSC_W-1:0] pc_r, pc_nxt;
  logic [7:0]       tc_r, tc_nxt;
  logic [7:0]       oc_r, oc_nxt;
  logic             lvl_r, lvl_nxt;
  logic             out_valid_r, out_valid_nxt;
  swte_out_t        out_data_r, out_data_nxt;

  logic             slot_free;
  logic             in_fire;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] q_shift;
  logic             q_fits;
  logic [7:0]       tc_inc;
  logic [7:0]       oc_inc;
  logic             load_out;

  swte_div #(
    .NW  (DIV_W),
    .DSW (DBL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(CLOCK_HZ)),
    .divisor  ({in_data.hz, 1'b0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;

  // trial quotient for the current prescaler
  assign q_shift = div_quo >> presc_shift(idx_r);
  assign q_fits  = (q_shift >= DIV_W'(2)) && (q_shift <= DIV_W'(65536));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    run_nxt   = run_r;
    sel_nxt   = sel_r;
    cmp_nxt   = cmp_r;
    pc_nxt    = pc_r;
    tc_nxt    = tc_r;
    oc_nxt    = oc_r;
    lvl_nxt   = lvl_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    tc_inc    = tc_r + 8'd1;
    oc_inc    = (tc_inc == 8'd0) ? (oc_r + 8'd1) : oc_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_TICK) begin
            load_out = 1'b1;
            if (run_r && (sel_r != SEL_STOP)) begin
              if (({1'b0, pc_r} + 11'd1) >= presc_div(sel_r)) begin
                pc_nxt = '0;
                tc_nxt = tc_inc;
                oc_nxt = oc_inc;
                // wrap counted before the match test
                if ((tc_inc == cmp_r[7:0]) && (oc_inc == cmp_r[15:8])) begin
                  lvl_nxt = ~lvl_r;
                  tc_nxt  = '0;
                  oc_nxt  = '0;
                end
              end else begin
                pc_nxt = pc_r + PSC_W'(1);
              end
            end
          end else begin
            run_nxt = 1'b0;
            sel_nxt = SEL_STOP;
            cmp_nxt = '0;
            pc_nxt  = '0;
            tc_nxt  = '0;
            oc_nxt  = '0;
            if (in_data.hz == '0) begin
              load_out = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          idx_nxt   = '0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (q_fits) begin
          sel_nxt   = idx_r + SEL_W'(1);
          cmp_nxt   = CMP_W'(q_shift - DIV_W'(1));
          run_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (idx_r == SEL_W'(NUM_PRESCALERS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + SEL_W'(1);
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt.wave_level    = lvl_nxt;
    out_data_nxt.running       = run_nxt;
    out_data_nxt.prescale_code = sel_nxt;
    out_data_nxt.compare_value = cmp_nxt;

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      run_r       <= 1'b0;
      sel_r       <= SEL_STOP;
      cmp_r       <= '0;
      pc_r        <= '0;
      tc_r        <= '0;
      oc_r        <= '0;
      lvl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      run_r       <= run_nxt;
      sel_r       <= sel_nxt;
      cmp_r       <= cmp_nxt;
      pc_r        <= pc_nxt;
      tc_r        <= tc_nxt;
      oc_r        <= oc_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for square_wave_timer_extended with directed and random beats
module tb_top;
  import swte_pkg::*;

  localparam int CLOCK_HZ       = 16000000;
  localparam int NUM_PRESC      = 7;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int DIR_ROWS       = 24;

  localparam int unsigned PRESC_TABLE [NUM_PRESC] = '{1, 8, 32, 64, 128, 256, 1024};

  typedef struct packed {
    bit        typed;
    swte_out_t val;
  } hint_t;

  typedef struct packed {
    swte_in_t  beat;
    bit        typed;
    swte_out_t val;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  swte_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  swte_out_t out_data;

  // predictor state
  bit              m_run = 1'b0;
  logic [2:0]      m_sel = SEL_STOP;
  logic [15:0]     m_cmp = '0;
  logic [9:0]      m_psc = '0;
  logic [7:0]      m_tmr = '0;
  logic [7:0]      m_ovf = '0;
  logic            m_lvl = 1'b0;

  hint_t     hint_q [$];
  swte_out_t predicted_q [$];
  dir_row_t  dir_rows [DIR_ROWS];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  src_quiet;
  int  snk_quiet;
  bit  held;

  square_wave_timer_extended #(
    .CLOCK_HZ      (CLOCK_HZ),
    .NUM_PRESCALERS(NUM_PRESC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // state after one beat: set restarts and searches, tick advances the counters
  task automatic wave_predict(input swte_in_t b, output swte_out_t r);
    longint unsigned twice;
    longint unsigned q;
    int unsigned     d;
    if (b.kind == KIND_SET) begin
      m_run = 1'b0;
      m_sel = SEL_STOP;
      m_cmp = '0;
      m_psc = '0;
      m_tmr = '0;
      m_ovf = '0;
      if (b.hz != '0) begin
        twice = {b.hz, 1'b0};
        for (int i = 0; i < NUM_PRESC && !m_run; i++) begin
          q = CLOCK_HZ / (twice * PRESC_TABLE[i]);
          if (q >= 2 && q <= 65536) begin
            m_sel = 3'(i + 1);
            m_cmp = 16'(q - 1);
            m_run = 1'b1;
          end
        end
      end
    end else if (m_run && m_sel != SEL_STOP) begin
      d = PRESC_TABLE[m_sel - 1];
      if (m_psc + 1 >= d) begin
        m_psc = '0;
        m_tmr = m_tmr + 8'd1;
        // wrap bumps the high count before the match test
        if (m_tmr == 8'd0) m_ovf = m_ovf + 8'd1;
        if (m_tmr == m_cmp[7:0] && m_ovf == m_cmp[15:8]) begin
          m_lvl = ~m_lvl;
          m_tmr = '0;
          m_ovf = '0;
        end
      end else begin
        m_psc = m_psc + 10'd1;
      end
    end
    r.wave_level    = m_lvl;
    r.running       = m_run;
    r.prescale_code = m_sel;
    r.compare_value = m_cmp;
  endtask

  always @(posedge clk) begin
    hint_t     h;
    swte_out_t p;
    swte_out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        wave_predict(in_data, p);
        h = hint_q.pop_front();
        predicted_q.push_back(h.typed ? h.val : p);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_q.size() == 0) begin
          $error("unexpected result beat: %p", out_data);
          mismatches++;
        end else begin
          e = predicted_q.pop_front();
          if (out_data.wave_level !== e.wave_level) begin
            $error("wave_level: expected %0d, got %0d", e.wave_level, out_data.wave_level);
            mismatches++;
          end
          if (out_data.running !== e.running) begin
            $error("running: expected %0d, got %0d", e.running, out_data.running);
            mismatches++;
          end
          if (out_data.prescale_code !== e.prescale_code) begin
            $error("prescale_code: expected %0d, got %0d",
                   e.prescale_code, out_data.prescale_code);
            mismatches++;
          end
          if (out_data.compare_value !== e.compare_value) begin
            $error("compare_value: expected %0d, got %0d",
                   e.compare_value, out_data.compare_value);
            mismatches++;
          end
        end
      end
    end
  end

  // present one beat after a random gap and hold it until taken
  task automatic offer(input swte_in_t beat, input bit typed, input swte_out_t val);
    int    gap;
    hint_t h;
    if (src_quiet > 0) begin
      gap = 0;
      src_quiet--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) src_quiet = 30;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    h.typed = typed;
    h.val   = val;
    hint_q.push_back(h);
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    swte_in_t b;
    int       sent;
    int       run_len;
    int       pause_at;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    src_quiet    = 0;

    // typed rows: stopped states, a few prescaler picks that are easy to work out by hand
    dir_rows = '{
      '{'{KIND_TICK, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, SEL_STOP, 16'd0}},
      '{'{KIND_SET,  16'd0},    1'b1, '{1'b0, 1'b0, SEL_STOP, 16'd0}},
      '{'{KIND_SET,  16'hFFFF}, 1'b1, '{1'b0, 1'b1, 3'd1, 16'd121}},
      '{'{KIND_TICK, 16'd0},    1'b0, '0},
      '{'{KIND_TICK, 16'hFFFF}, 1'b0, '0},
      '{'{KIND_SET,  16'd1},    1'b1, '{1'b0, 1'b1, 3'd5, 16'd62499}},
      '{'{KIND_TICK, 16'd0},    1'b0, '0},
      '{'{KIND_SET,  16'd2},    1'b1, '{1'b0, 1'b1, 3'd4, 16'd62499}},
      '{'{KIND_SET,  16'd3},    1'b1, '{1'b0, 1'b1, 3'd4, 16'd41665}},
      '{'{KIND_SET,  16'd7},    1'b1, '{1'b0, 1'b1, 3'd3, 16'd35713}},
      '{'{KIND_SET,  16'd15},   1'b0, '0},
      '{'{KIND_SET,  16'd122},  1'b0, '0},
      '{'{KIND_TICK, 16'd0},    1'b0, '0},
      '{'{KIND_SET,  16'd123},  1'b0, '0},
      '{'{KIND_TICK, 16'd0},    1'b0, '0},
      '{'{KIND_SET,  16'd31250}, 1'b1, '{1'b0, 1'b1, 3'd1, 16'd255}},
      '{'{KIND_SET,  16'd31128}, 1'b0, '0},
      '{'{KIND_TICK, 16'd0},    1'b0, '0},
      '{'{KIND_SET,  16'd20000}, 1'b0, '0},
      '{'{KIND_TICK, 16'h5555}, 1'b0, '0},
      '{'{KIND_SET,  16'd0},    1'b1, '{1'b0, 1'b0, SEL_STOP, 16'd0}},
      '{'{KIND_TICK, 16'hAAAA}, 1'b1, '{1'b0, 1'b0, SEL_STOP, 16'd0}},
      '{'{KIND_SET,  16'hAAAA}, 1'b0, '0},
      '{'{KIND_TICK, 16'h5555}, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].val);

    // random part: each set is followed by a short run of ticks or a longer one that can show toggles
    sent     = 0;
    pause_at = $urandom_range(400, 600);
    while (sent < RANDOM_ITEMS) begin
      b.kind = KIND_SET;
      case ($urandom_range(0, 9))
        0:       b.hz = '0;
        1, 2:    b.hz = 16'($urandom_range(1, 130));
        3, 4:    b.hz = 16'($urandom);
        5: begin
          case ($urandom_range(0, 3))
            0:       b.hz = 16'd31128;
            1:       b.hz = 16'd31250;
            2:       b.hz = 16'hFFFF;
            default: b.hz = 16'd123;
          endcase
        end
        default: b.hz = 16'($urandom_range(20000, 65535));
      endcase
      offer(b, 1'b0, '0);
      sent++;
      run_len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 10) : $urandom_range(120, 300);
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        b.kind = KIND_TICK;
        b.hz   = 16'($urandom);
        offer(b, 1'b0, '0);
        sent++;
        if (sent == pause_at) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_q.size() == 0 && hint_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int stall;
    out_ready <= 1'b0;
    held       = 1'b0;
    snk_quiet  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (snk_quiet > 0) begin
        stall = 0;
        snk_quiet--;
      end else begin
        stall = $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) snk_quiet = 30;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule
